>>> rtl/core/svcap_pkg.sv
// Package for the SH velocity CPML adjoint point block.
// Holds shared widths, status and register codes, pipeline payload types and saturation.
// No dependencies.
`default_nettype none

package svcap_pkg;

    localparam int DW        = 32;
    localparam int FRAC      = 20;
    localparam int NUM_TAPS  = 6;
    localparam int MAX_ORDER = 12;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_PSI = 2'd2
    } status_t;

    localparam logic [3:0] REG_DT    = 4'd0;
    localparam logic [3:0] REG_ORDER = 4'd1;
    localparam logic [3:0] REG_TAP1  = 4'd2;
    localparam logic [3:0] REG_TAP2  = 4'd3;
    localparam logic [3:0] REG_TAP3  = 4'd4;
    localparam logic [3:0] REG_TAP4  = 4'd5;
    localparam logic [3:0] REG_TAP5  = 4'd6;
    localparam logic [3:0] REG_TAP6  = 4'd7;

    typedef logic [NUM_TAPS-1:0][DW-1:0] coef_t;

    typedef struct packed {
        status_t            st;
        logic signed [31:0] vz;
        logic               on_x;
        logic               on_y;
        logic signed [31:0] q;
        logic signed [31:0] dpsi_x;
        logic signed [31:0] dpsi_y;
        logic signed [31:0] at_x;
        logic signed [31:0] at_y;
    } side_t;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] quo;
        logic [31:0] lo;
        logic [31:0] k;
        logic        neg;
        logic        ovf;
    } div_t;

    function automatic logic signed [31:0] sat_q(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] mul_floor(input logic signed [63:0] p);
        logic signed [63:0] sh;
        sh = p >>> FRAC;
        return sat_q($signed({{2{sh[63]}}, sh}));
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/svcap_front.sv
// Front pipeline: alpha, q, status, psi sums, CPML products and divider setup.
// Six register stages. Depends on svcap_pkg.
`default_nettype none

module svcap_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               start,
    input  wire logic signed [31:0] vz_adjoint_next,
    input  wire logic [30:0]        inv_density,
    input  wire logic signed [31:0] psi_next_x,
    input  wire logic signed [31:0] psi_next_y,
    input  wire logic               pml_on_x,
    input  wire logic               pml_on_y,
    input  wire logic signed [31:0] stretch_x,
    input  wire logic signed [31:0] shift_x,
    input  wire logic signed [31:0] decay_x,
    input  wire logic signed [31:0] stretch_y,
    input  wire logic signed [31:0] shift_y,
    input  wire logic signed [31:0] decay_y,
    input  wire logic [30:0]        dt_over_dh,
    input  wire logic [3:0]         fd_order,
    output logic                    valid,
    output svcap_pkg::side_t        side,
    output svcap_pkg::div_t         div_x,
    output svcap_pkg::div_t         div_y
);

    typedef struct packed {
        logic               on;
        logic signed [31:0] psi;
        logic signed [31:0] k;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } axis_t;

    logic [5:0] v_reg;

    svcap_pkg::status_t st_next;
    svcap_pkg::status_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    logic [61:0]        prod1_reg;
    logic signed [31:0] alpha2_reg;
    logic signed [63:0] pq3_reg;
    logic signed [31:0] q4_reg, q5_reg;
    logic signed [31:0] tx4_reg, ty4_reg;
    logic signed [63:0] pbx5_reg, pax5_reg, pby5_reg, pay5_reg;
    logic signed [31:0] vz1_reg, vz2_reg, vz3_reg, vz4_reg, vz5_reg;
    axis_t              ax1_reg, ax2_reg, ax3_reg, ax4_reg;
    axis_t              ay1_reg, ay2_reg, ay3_reg, ay4_reg;
    logic               onx5_reg, ony5_reg;
    logic signed [31:0] kx5_reg, ky5_reg;
    logic               order_bad;

    svcap_pkg::side_t side_next;
    svcap_pkg::div_t  dx_next, dy_next;
    svcap_pkg::side_t side_reg;
    svcap_pkg::div_t  dx_reg, dy_reg;

    function automatic svcap_pkg::div_t div_init(input logic signed [31:0] q,
                                                 input logic signed [31:0] k);
        svcap_pkg::div_t d;
        logic [32:0]     absq;
        absq  = q[31] ? 33'(-$signed({q[31], q})) : {1'b0, q};
        d.r   = 32'(absq >> 12);
        d.lo  = {absq[11:0], 20'b0};
        d.quo = '0;
        d.k   = k;
        d.neg = q[31];
        d.ovf = ({12'b0, absq} >= {1'b0, k, 12'b0});
        return d;
    endfunction

    assign order_bad = (fd_order < 4'd2) || (fd_order > 4'd12) || fd_order[0]
                       || (32'(fd_order) > 32'(svcap_pkg::MAX_ORDER));

    always_comb
    begin
        st_next = svcap_pkg::ST_OK;
        if (dt_over_dh == '0 || inv_density == '0)
            st_next = svcap_pkg::ST_BAD;
        else if (!pml_on_x && psi_next_x != '0)
            st_next = svcap_pkg::ST_PSI;
        else if (pml_on_x && stretch_x <= 0)
            st_next = svcap_pkg::ST_BAD;
        else if (!pml_on_y && psi_next_y != '0)
            st_next = svcap_pkg::ST_PSI;
        else if (pml_on_y && stretch_y <= 0)
            st_next = svcap_pkg::ST_BAD;
        else if (order_bad)
            st_next = svcap_pkg::ST_BAD;
    end

    always_comb
    begin
        side_next.st     = st5_reg;
        side_next.vz     = vz5_reg;
        side_next.on_x   = onx5_reg;
        side_next.on_y   = ony5_reg;
        side_next.q      = q5_reg;
        side_next.dpsi_x = onx5_reg ? svcap_pkg::mul_floor(pbx5_reg) : 32'sd0;
        side_next.dpsi_y = ony5_reg ? svcap_pkg::mul_floor(pby5_reg) : 32'sd0;
        side_next.at_x   = svcap_pkg::mul_floor(pax5_reg);
        side_next.at_y   = svcap_pkg::mul_floor(pay5_reg);
        dx_next          = div_init(q5_reg, kx5_reg);
        dy_next          = div_init(q5_reg, ky5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[4:0], start};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg   <= st_next;
            prod1_reg <= 62'(dt_over_dh) * 62'(inv_density);
            vz1_reg   <= vz_adjoint_next;
            ax1_reg   <= '{pml_on_x, psi_next_x, stretch_x, shift_x, decay_x};
            ay1_reg   <= '{pml_on_y, psi_next_y, stretch_y, shift_y, decay_y};

            st2_reg    <= st1_reg;
            alpha2_reg <= (prod1_reg[61:51] != '0) ? 32'sh7FFFFFFF
                                                   : $signed({1'b0, prod1_reg[50:20]});
            vz2_reg    <= vz1_reg;
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;

            st3_reg <= st2_reg;
            pq3_reg <= 64'(alpha2_reg) * 64'(vz2_reg);
            vz3_reg <= vz2_reg;
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;

            st4_reg <= st3_reg;
            q4_reg  <= svcap_pkg::mul_floor(pq3_reg);
            vz4_reg <= vz3_reg;
            ax4_reg <= ax3_reg;
            ay4_reg <= ay3_reg;
            tx4_reg <= svcap_pkg::sat_q(66'(ax3_reg.psi)
                                        + 66'(svcap_pkg::mul_floor(pq3_reg)));
            ty4_reg <= svcap_pkg::sat_q(66'(ay3_reg.psi)
                                        + 66'(svcap_pkg::mul_floor(pq3_reg)));

            st5_reg  <= st4_reg;
            q5_reg   <= q4_reg;
            vz5_reg  <= vz4_reg;
            onx5_reg <= ax4_reg.on;
            ony5_reg <= ay4_reg.on;
            kx5_reg  <= ax4_reg.k;
            ky5_reg  <= ay4_reg.k;
            pbx5_reg <= 64'(ax4_reg.b) * 64'(tx4_reg);
            pax5_reg <= 64'(ax4_reg.a) * 64'(tx4_reg);
            pby5_reg <= 64'(ay4_reg.b) * 64'(ty4_reg);
            pay5_reg <= 64'(ay4_reg.a) * 64'(ty4_reg);

            side_reg <= side_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
        end
    end

    assign valid = v_reg[5];
    assign side  = side_reg;
    assign div_x = dx_reg;
    assign div_y = dy_reg;

endmodule

`default_nettype wire

>>> rtl/core/svcap_div.sv
// Pipelined restoring divider for q*2^20/K on both axes, two quotient bits per stage.
// Carries the side payload alongside. Depends on svcap_pkg.
`default_nettype none

module svcap_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire svcap_pkg::side_t in_side,
    input  wire svcap_pkg::div_t  in_x,
    input  wire svcap_pkg::div_t  in_y,
    output logic                  out_valid,
    output svcap_pkg::side_t      out_side,
    output svcap_pkg::div_t       out_x,
    output svcap_pkg::div_t       out_y
);

    localparam int STAGES = 16;

    logic [STAGES-1:0] v_reg;
    svcap_pkg::side_t  side_reg [STAGES];
    svcap_pkg::div_t   dx_reg   [STAGES];
    svcap_pkg::div_t   dy_reg   [STAGES];

    function automatic svcap_pkg::div_t step(input svcap_pkg::div_t d);
        svcap_pkg::div_t o;
        logic [32:0]     r2;
        logic            ge;
        r2    = {d.r, d.lo[31]};
        ge    = (r2 >= {1'b0, d.k});
        o     = d;
        o.r   = ge ? 32'(r2 - {1'b0, d.k}) : r2[31:0];
        o.quo = {d.quo[30:0], ge};
        o.lo  = {d.lo[30:0], 1'b0};
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            dx_reg[0]   <= step(step(in_x));
            dy_reg[0]   <= step(step(in_y));
            for (int i = 1; i < STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                dx_reg[i]   <= step(step(dx_reg[i-1]));
                dy_reg[i]   <= step(step(dy_reg[i-1]));
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_x     = dx_reg[STAGES-1];
    assign out_y     = dy_reg[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/svcap_emit.sv
// Result sequencer: finishes raw derivatives, emits the point result, then taps if OK.
// Registered outputs, one result per cycle. Depends on svcap_pkg.
`default_nettype none

module svcap_emit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire svcap_pkg::side_t   side,
    input  wire svcap_pkg::div_t    div_x,
    input  wire svcap_pkg::div_t    div_y,
    input  wire logic [3:0]         fd_order,
    input  wire svcap_pkg::coef_t   coef,
    output logic                    ready,
    output logic                    result_strobe,
    output logic [2:0]              tap,
    output logic signed [31:0]      delta_vz_prev,
    output logic signed [31:0]      delta_psi_x,
    output logic signed [31:0]      delta_psi_y,
    output logic signed [31:0]      x_term,
    output logic signed [31:0]      y_term,
    output logic [1:0]              status,
    output logic                    last
);

    logic               pend_reg, pend_next;
    logic [2:0]         tap_reg, tap_next;
    logic [2:0]         half_reg;
    logic signed [31:0] raw_x_reg, raw_y_reg;
    logic signed [31:0] raw_x, raw_y;
    logic               strobe_reg, strobe_next;
    logic [2:0]         tap_o_reg, tap_o_next;
    logic signed [31:0] dvz_reg, dvz_next;
    logic signed [31:0] dpx_reg, dpx_next;
    logic signed [31:0] dpy_reg, dpy_next;
    logic signed [31:0] xt_reg, xt_next;
    logic signed [31:0] yt_reg, yt_next;
    logic [1:0]         st_reg, st_next;
    logic               last_reg, last_next;
    logic [2:0]         tap_idx;
    logic signed [31:0] c;

    function automatic logic signed [31:0] quot(input svcap_pkg::div_t d);
        logic [31:0] mag;
        mag = d.quo;
        if (d.ovf)
            return d.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else if (d.neg)
            return (mag > 32'h80000000) ? 32'sh80000000 : $signed(-mag);
        else
            return mag[31] ? 32'sh7FFFFFFF : $signed(mag);
    endfunction

    assign raw_x = side.on_x ? svcap_pkg::sat_q(66'(quot(div_x)) + 66'(side.at_x)) : side.q;
    assign raw_y = side.on_y ? svcap_pkg::sat_q(66'(quot(div_y)) + 66'(side.at_y)) : side.q;

    assign tap_idx = tap_reg - 3'd1;
    assign c       = $signed(coef[tap_idx]);
    assign ready   = !pend_reg;

    always_comb
    begin
        pend_next   = pend_reg;
        tap_next    = tap_reg;
        strobe_next = 1'b0;
        tap_o_next  = tap_o_reg;
        dvz_next    = dvz_reg;
        dpx_next    = dpx_reg;
        dpy_next    = dpy_reg;
        xt_next     = xt_reg;
        yt_next     = yt_reg;
        st_next     = st_reg;
        last_next   = last_reg;
        if (load)
        begin
            strobe_next = 1'b1;
            tap_o_next  = 3'd0;
            xt_next     = '0;
            yt_next     = '0;
            st_next     = side.st;
            tap_next    = 3'd1;
            if (side.st == svcap_pkg::ST_OK)
            begin
                dvz_next  = side.vz;
                dpx_next  = side.dpsi_x;
                dpy_next  = side.dpsi_y;
                last_next = 1'b0;
                pend_next = 1'b1;
            end
            else
            begin
                dvz_next  = '0;
                dpx_next  = '0;
                dpy_next  = '0;
                last_next = 1'b1;
                pend_next = 1'b0;
            end
        end
        else if (pend_reg)
        begin
            strobe_next = 1'b1;
            tap_o_next  = tap_reg;
            dvz_next    = '0;
            dpx_next    = '0;
            dpy_next    = '0;
            xt_next     = svcap_pkg::mul_floor(64'(c) * 64'(raw_x_reg));
            yt_next     = svcap_pkg::mul_floor(64'(c) * 64'(raw_y_reg));
            st_next     = svcap_pkg::ST_OK;
            last_next   = (tap_reg == half_reg);
            pend_next   = (tap_reg != half_reg);
            tap_next    = tap_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            tap_reg    <= 3'd1;
            half_reg   <= 3'd1;
        end
        else
        begin
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
            tap_reg    <= tap_next;
            if (load)
                half_reg <= fd_order[3:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            raw_x_reg <= raw_x;
            raw_y_reg <= raw_y;
        end
        tap_o_reg <= tap_o_next;
        dvz_reg   <= dvz_next;
        dpx_reg   <= dpx_next;
        dpy_reg   <= dpy_next;
        xt_reg    <= xt_next;
        yt_reg    <= yt_next;
        st_reg    <= st_next;
        last_reg  <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign tap           = tap_o_reg;
    assign delta_vz_prev = dvz_reg;
    assign delta_psi_x   = dpx_reg;
    assign delta_psi_y   = dpy_reg;
    assign x_term        = xt_reg;
    assign y_term        = yt_reg;
    assign status        = st_reg;
    assign last          = last_reg;

`ifndef ASSERT_OFF
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && status != svcap_pkg::ST_OK |-> last && tap == 3'd0)
        else $error("error request not a single final result");

    a_last_tap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last && status == svcap_pkg::ST_OK |-> tap == half_reg)
        else $error("final tap does not match order");

    a_tap_follow: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !load |=> result_strobe && tap == $past(tap_reg))
        else $error("tap result missing");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !load)
        else $error("request loaded while taps pending");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sh_velocity_cpml_adjoint_point_top.sv
// Top level of the SH velocity CPML adjoint point block.
// Holds configuration registers; instantiates svcap_front, svcap_div, svcap_emit.
// Depends on svcap_pkg.
//
// Usage:
//  - A request is taken at a rising edge with start high and busy low; its
//    fields sit on the input ports at that edge.
//  - Configuration: wr_en/wr_index/wr_data write register wr_index at the
//    edge; indexes past the last tap coefficient are ignored. Write only
//    while idle.
//  - Results: one per cycle, marked by result_strobe for exactly one cycle.
//    A good request gives a point result (tap 0) then one result per tap up
//    to fd_order/2, last set on the final one. A failing request gives one
//    result carrying the status code with last set.
//  - Pipeline: a request crosses 6 front stages and 16 divider stages, both
//    held while busy is high, then the output stage strobes its point result.
//  - Flow: all results share the single result port. The pipeline stalls
//    (busy high) only while a request waits at the divider output and the
//    sequencer still emits tap results of the previous request.
//  - Reset clears all valid bits and loads register defaults; no result is
//    strobed until a request has crossed the pipeline.
`default_nettype none

module sh_velocity_cpml_adjoint_point_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] vz_adjoint_next,
    input  wire logic [30:0]        inv_density,
    input  wire logic signed [31:0] psi_next_x,
    input  wire logic signed [31:0] psi_next_y,
    input  wire logic               pml_on_x,
    input  wire logic               pml_on_y,
    input  wire logic signed [31:0] stretch_x,
    input  wire logic signed [31:0] shift_x,
    input  wire logic signed [31:0] decay_x,
    input  wire logic signed [31:0] stretch_y,
    input  wire logic signed [31:0] shift_y,
    input  wire logic signed [31:0] decay_y,
    input  wire logic               wr_en,
    input  wire logic [3:0]         wr_index,
    input  wire logic [31:0]        wr_data,
    output logic                    result_strobe,
    output logic [2:0]              tap,
    output logic signed [31:0]      delta_vz_prev,
    output logic signed [31:0]      delta_psi_x,
    output logic signed [31:0]      delta_psi_y,
    output logic signed [31:0]      x_term,
    output logic signed [31:0]      y_term,
    output logic [1:0]              status,
    output logic                    last
);

    logic [30:0]       dt_reg;
    logic [3:0]        order_reg;
    svcap_pkg::coef_t  coef_reg;

    logic              adv;
    logic              emit_ready;
    logic              f_valid, d_valid;
    svcap_pkg::side_t  f_side, d_side;
    svcap_pkg::div_t   f_x, f_y, d_x, d_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg      <= 31'd1048576;
            order_reg   <= 4'd4;
            coef_reg    <= '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1048576};
        end
        else if (wr_en)
        begin
            case (wr_index)
                svcap_pkg::REG_DT:    dt_reg      <= wr_data[30:0];
                svcap_pkg::REG_ORDER: order_reg   <= wr_data[3:0];
                svcap_pkg::REG_TAP1:  coef_reg[0] <= wr_data;
                svcap_pkg::REG_TAP2:  coef_reg[1] <= wr_data;
                svcap_pkg::REG_TAP3:  coef_reg[2] <= wr_data;
                svcap_pkg::REG_TAP4:  coef_reg[3] <= wr_data;
                svcap_pkg::REG_TAP5:  coef_reg[4] <= wr_data;
                svcap_pkg::REG_TAP6:  coef_reg[5] <= wr_data;
                default: ;
            endcase
        end
    end

    assign adv  = !d_valid || emit_ready;
    assign busy = !adv;

    svcap_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .start           (start),
        .vz_adjoint_next (vz_adjoint_next),
        .inv_density     (inv_density),
        .psi_next_x      (psi_next_x),
        .psi_next_y      (psi_next_y),
        .pml_on_x        (pml_on_x),
        .pml_on_y        (pml_on_y),
        .stretch_x       (stretch_x),
        .shift_x         (shift_x),
        .decay_x         (decay_x),
        .stretch_y       (stretch_y),
        .shift_y         (shift_y),
        .decay_y         (decay_y),
        .dt_over_dh      (dt_reg),
        .fd_order        (order_reg),
        .valid           (f_valid),
        .side            (f_side),
        .div_x           (f_x),
        .div_y           (f_y)
    );

    svcap_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_x      (f_x),
        .in_y      (f_y),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_x     (d_x),
        .out_y     (d_y)
    );

    svcap_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (d_valid && emit_ready),
        .side          (d_side),
        .div_x         (d_x),
        .div_y         (d_y),
        .fd_order      (order_reg),
        .coef          (coef_reg),
        .ready         (emit_ready),
        .result_strobe (result_strobe),
        .tap           (tap),
        .delta_vz_prev (delta_vz_prev),
        .delta_psi_x   (delta_psi_x),
        .delta_psi_y   (delta_psi_y),
        .x_term        (x_term),
        .y_term        (y_term),
        .status        (status),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for sh_velocity_cpml_adjoint_point_top: directed table then random requests.
// Predicts every result in fixed point and checks each strobed result in order.
// Depends on svcap_pkg and the RTL top level.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         tap;
        logic signed [31:0] dv;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] xt;
        logic signed [31:0] yt;
        logic [1:0]         st;
        logic               lst;
    } res_t;

    typedef struct packed {
        logic signed [31:0] vz;
        logic [30:0]        rho;
        logic signed [31:0] psx;
        logic signed [31:0] psy;
        logic               onx;
        logic               ony;
        logic signed [31:0] kx;
        logic signed [31:0] ax;
        logic signed [31:0] bx;
        logic signed [31:0] ky;
        logic signed [31:0] ay;
        logic signed [31:0] by;
    } req_t;

    logic clk = 0, rst_n = 0, start = 0, busy;
    req_t cur = '0;
    logic wr_en = 0;
    logic [3:0] wr_index = '0;
    logic [31:0] wr_data = '0;
    logic result_strobe;
    res_t got;
    res_t pending[$];
    int errors = 0;

    logic [30:0] m_dt;
    logic [3:0]  m_ord;
    logic signed [31:0] m_tap[svcap_pkg::NUM_TAPS];

    sh_velocity_cpml_adjoint_point_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vz_adjoint_next(cur.vz), .inv_density(cur.rho),
        .psi_next_x(cur.psx), .psi_next_y(cur.psy),
        .pml_on_x(cur.onx), .pml_on_y(cur.ony),
        .stretch_x(cur.kx), .shift_x(cur.ax), .decay_x(cur.bx),
        .stretch_y(cur.ky), .shift_y(cur.ay), .decay_y(cur.by),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_strobe(result_strobe), .tap(got.tap), .delta_vz_prev(got.dv),
        .delta_psi_x(got.px), .delta_psi_y(got.py), .x_term(got.xt),
        .y_term(got.yt), .status(got.st), .last(got.lst)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clip(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clip((a * b) >>> svcap_pkg::FRAC);
    endfunction

    function automatic svcap_pkg::status_t axis_grad(input logic on, input longint k,
                                                     input longint a, input longint b,
                                                     input longint q, input longint psi,
                                                     output longint raw, output longint dpsi);
        longint t;
        dpsi = 0;
        raw = q;
        if (!on)
            return (psi != 0) ? svcap_pkg::ST_PSI : svcap_pkg::ST_OK;
        if (k <= 0)
            return svcap_pkg::ST_BAD;
        t = clip(psi + q);
        dpsi = qmul(b, t);
        raw = clip(clip((q * 64'sd1048576) / k) + qmul(a, t));
        return svcap_pkg::ST_OK;
    endfunction

    task automatic predict_request(input req_t r);
        longint q, rx, ry, dx, dy;
        svcap_pkg::status_t s;
        res_t e;
        int half;
        s = svcap_pkg::ST_OK;
        rx = 0; ry = 0; dx = 0; dy = 0;
        if (m_dt == 0 || r.rho == 0)
            s = svcap_pkg::ST_BAD;
        if (s == svcap_pkg::ST_OK)
        begin
            q = qmul(qmul(longint'(m_dt), longint'(r.rho)), longint'(r.vz));
            s = axis_grad(r.onx, r.kx, r.ax, r.bx, q, r.psx, rx, dx);
            if (s == svcap_pkg::ST_OK)
                s = axis_grad(r.ony, r.ky, r.ay, r.by, q, r.psy, ry, dy);
        end
        if (s == svcap_pkg::ST_OK && (m_ord < 2 || m_ord > svcap_pkg::MAX_ORDER || m_ord[0]))
            s = svcap_pkg::ST_BAD;
        if (s != svcap_pkg::ST_OK)
        begin
            e = '0;
            e.st = s;
            e.lst = 1;
            pending.push_back(e);
            return;
        end
        half = int'(m_ord) / 2;
        e = '0;
        e.dv = r.vz; e.px = 32'(dx); e.py = 32'(dy);
        pending.push_back(e);
        for (int m = 1; m <= half; m++)
        begin
            e = '0;
            e.tap = 3'(m);
            e.xt = 32'(qmul(m_tap[m-1], rx));
            e.yt = 32'(qmul(m_tap[m-1], ry));
            e.lst = (m == half);
            pending.push_back(e);
        end
    endtask

    always @(posedge clk)
    begin
        if (result_strobe)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end
            else
            begin
                if (got !== pending[0])
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, pending[0], got);
                    errors++;
                end
                void'(pending.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        @(posedge clk);
        wr_en <= 1; wr_index <= idx; wr_data <= val;
        @(posedge clk);
        wr_en <= 0;
        case (idx)
            svcap_pkg::REG_DT:    m_dt = val[30:0];
            svcap_pkg::REG_ORDER: m_ord = val[3:0];
            default:
                if (idx <= svcap_pkg::REG_TAP6)
                    m_tap[3'(idx - svcap_pkg::REG_TAP1)] = val;
        endcase
    endtask

    task automatic drain();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    int burst = 0;
    task automatic send(input req_t r);
        int gap;
        gap = 0;
        if (burst == 0)
        begin
            gap = $urandom_range(0, 6);
            burst = $urandom_range(1, 12);
        end
        burst--;
        if (gap != 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        cur <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(r);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) << 20;
            3: return $urandom;
            default: return $signed($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic req_t rnd_req();
        req_t r;
        r.vz = rnd_val();
        r.rho = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 2097152));
        if ($urandom_range(0, 40) == 0) r.rho = 0;
        r.onx = 1'($urandom); r.ony = 1'($urandom);
        r.psx = (r.onx || $urandom_range(0, 9) == 0) ? rnd_val() : 0;
        r.psy = (r.ony || $urandom_range(0, 9) == 0) ? rnd_val() : 0;
        r.kx = ($urandom_range(0, 15) == 0) ? rnd_val() : $urandom_range(1, 32'h7FFFFFFF);
        r.ky = ($urandom_range(0, 15) == 0) ? rnd_val() : $urandom_range(1, 32'h7FFFFFFF);
        r.ax = rnd_val(); r.bx = rnd_val(); r.ay = rnd_val(); r.by = rnd_val();
        return r;
    endfunction

    typedef struct {
        req_t r;
        logic chk;
        res_t e;
    } row_t;

    initial
    begin
        row_t rows[$];
        row_t w;
        req_t b;
        m_dt = 31'd1048576; m_ord = 4'd4;
        foreach (m_tap[i]) m_tap[i] = (i == 0) ? 32'sd1048576 : 32'sd0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        b = '0;
        b.vz = 32'sd1048576; b.rho = 31'd1048576;
        b.kx = 32'sd1048576; b.ky = 32'sd1048576;
        w.r = b; w.chk = 0; w.e = '0; rows.push_back(w);
        w.r = b; w.r.rho = 0; w.chk = 1; w.e = '0; w.e.st = svcap_pkg::ST_BAD; w.e.lst = 1;
        rows.push_back(w);
        w.r = b; w.r.psx = 32'sd5; w.chk = 1; rows.push_back(w);
        w.e.st = svcap_pkg::ST_PSI; rows[2].e = w.e;
        w.r = b; w.r.psy = 32'sh80000000; rows.push_back(w);
        w.r = b; w.r.onx = 1; w.r.kx = 0; w.e.st = svcap_pkg::ST_BAD; rows.push_back(w);
        w.r = b; w.r.ony = 1; w.r.ky = 32'sh80000000; rows.push_back(w);
        w.chk = 0;
        w.r = b; w.r.vz = 32'sh7FFFFFFF; w.r.rho = 31'h7FFFFFFF; rows.push_back(w);
        w.r = b; w.r.vz = 32'sh80000000; w.r.onx = 1; w.r.ony = 1;
        w.r.kx = 32'sd1; w.r.ky = 32'sh7FFFFFFF; w.r.ax = 32'sh80000000;
        w.r.bx = 32'sh7FFFFFFF; w.r.ay = 32'sh7FFFFFFF; w.r.by = 32'sh80000000;
        w.r.psx = 32'sh7FFFFFFF; w.r.psy = 32'sh80000000; rows.push_back(w);
        w.r = b; w.r.onx = 1; w.r.ony = 1; w.r.kx = 32'sd2097152; w.r.ky = 32'sd524288;
        w.r.ax = 32'sd1000; w.r.bx = -32'sd2000; w.r.ay = -32'sd3; w.r.by = 32'sd7;
        w.r.psx = -32'sd12345; w.r.psy = 32'sd999; w.r.vz = -32'sd77777; rows.push_back(w);
        foreach (rows[i])
        begin
            send(rows[i].r);
            if (rows[i].chk && pending[pending.size()-1] !== rows[i].e)
            begin
                $display("%0t: table row %0d expected %p actual %p", $time, i,
                         rows[i].e, pending[pending.size()-1]);
                errors++;
            end
        end
        start <= 0;
        drain();
        write_reg(svcap_pkg::REG_ORDER, 32'd12);
        for (int i = 0; i < svcap_pkg::NUM_TAPS; i++)
            write_reg(4'(svcap_pkg::REG_TAP1 + i), rnd_val());
        write_reg(4'd9, 32'hFFFFFFFF);
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int n = 0; n < 80; n++)
                send(rnd_req());
            start <= 0;
            drain();
            case (ph)
                0: begin
                    write_reg(svcap_pkg::REG_DT, 32'h7FFFFFFF);
                    write_reg(svcap_pkg::REG_ORDER, 32'd2);
                end
                1: begin
                    write_reg(svcap_pkg::REG_DT, 32'd0);
                    write_reg(svcap_pkg::REG_ORDER, 32'd7);
                end
                2: begin
                    write_reg(svcap_pkg::REG_DT, $urandom);
                    write_reg(svcap_pkg::REG_ORDER, 32'd14);
                end
                3: begin
                    write_reg(svcap_pkg::REG_DT, 32'd1);
                    write_reg(svcap_pkg::REG_ORDER, 32'd0);
                end
                default: begin
                    write_reg(svcap_pkg::REG_DT, 32'd1048576);
                    write_reg(svcap_pkg::REG_ORDER, 32'd8);
                end
            endcase
            for (int i = 0; i < svcap_pkg::NUM_TAPS; i++)
                write_reg(4'(svcap_pkg::REG_TAP1 + i), rnd_val());
        end
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
rtl/core/svcap_pkg.sv
rtl/core/svcap_front.sv
rtl/core/svcap_div.sv
rtl/core/svcap_emit.sv
rtl/core/sh_velocity_cpml_adjoint_point_top.sv
tb/tb_top.sv
